// ----- src/svf_pkg.sv -----
// ----------------------------------------------------------------------------
// svf_pkg
// Shared types, widths and constants of the state variable filter core.
// ----------------------------------------------------------------------------
package svf_pkg;

   // Field and state widths
   localparam int FS_W  = 18;
   localparam int X_W   = 24;
   localparam int FC_W  = 16;
   localparam int Q_W   = 16;
   localparam int ST_W  = 32;

   // Shared multiplier and divider
   localparam int MUL_W  = 34;
   localparam int PROD_W = 2 * MUL_W;
   localparam int DIV_NW = 56;
   localparam int DIV_DW = 36;
   localparam int DIV_CW = 6;

   // Working registers
   localparam int TH_W  = 31;
   localparam int T2_W  = 32;
   localparam int TS_W  = 32;
   localparam int SC_W  = 34;
   localparam int G_W   = 31;
   localparam int TR_W  = 28;
   localparam int DEN_W = 36;
   localparam int D_W   = 27;
   localparam int G0_W  = 32;
   localparam int IN_W  = 40;

   // Reciprocal constants for the Taylor term divisions
   localparam int RCP_W = 33;
   localparam int SH_W  = 4;

   localparam logic [FS_W-1:0] FS_MIN   = 18'd8000;
   localparam logic [FS_W-1:0] FS_MAX   = 18'd192000;
   localparam logic [FS_W-1:0] FS_RESET = 18'd48000;
   localparam logic [FC_W-1:0] FC_MIN   = 16'd20;
   localparam logic [FC_W-1:0] FC_MAX   = 16'd20000;
   localparam logic [Q_W-1:0]  Q_MIN    = 16'd410;
   localparam logic [Q_W-1:0]  Q_MAX    = 16'd40960;

   localparam logic [31:0]     PI_Q30    = 32'd3373259426;
   localparam logic [TH_W-1:0] THETA_CAP = 31'd1652897119;
   localparam logic [TS_W-1:0] ONE_Q30   = 32'h4000_0000;
   localparam logic [DEN_W-1:0] ONE_Q24  = 36'h0_0100_0000;

   localparam logic signed [PROD_W-1:0] HALF24 = 68'sd8388608;
   localparam logic signed [PROD_W-1:0] HALF26 = 68'sd33554432;
   localparam logic signed [PROD_W-1:0] S32_MAX = 68'sd2147483647;
   localparam logic signed [PROD_W-1:0] S32_MIN = -68'sd2147483648;

   // ceil(2^(32+sh) / dv); with 2^(sh-1) < dv <= 2^sh the product n * m
   // shifted right by 32+sh gives floor(n / dv) exactly for any n < 2^32
   function automatic logic [RCP_W-1:0] rcp_of(input int unsigned dv,
                                                input int unsigned sh);
      logic [63:0] num;
      num = (64'd1 << (32 + sh)) + 64'(dv) - 64'd1;
      return RCP_W'(num / 64'(dv));
   endfunction

   // Taylor term divisors 6, 20, 42, 72, 110, 156, 210, 272 (sin) and
   // 2, 12, 30, 56, 90, 132, 182, 240 (cos), one per term index
   localparam logic [SH_W-1:0] SIN_SH [0:7] = '{4'd3, 4'd5, 4'd6, 4'd7,
                                                4'd7, 4'd8, 4'd8, 4'd9};
   localparam logic [SH_W-1:0] COS_SH [0:7] = '{4'd1, 4'd4, 4'd5, 4'd6,
                                                4'd7, 4'd8, 4'd8, 4'd8};
   localparam logic [RCP_W-1:0] SIN_RCP [0:7] = '{
      rcp_of(6, 3), rcp_of(20, 5), rcp_of(42, 6), rcp_of(72, 7),
      rcp_of(110, 7), rcp_of(156, 8), rcp_of(210, 8), rcp_of(272, 9)};
   localparam logic [RCP_W-1:0] COS_RCP [0:7] = '{
      rcp_of(2, 1), rcp_of(12, 4), rcp_of(30, 5), rcp_of(56, 6),
      rcp_of(90, 7), rcp_of(132, 8), rcp_of(182, 8), rcp_of(240, 8)};

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_TH_MUL, ST_TH_DIV, ST_TH_WAIT,
      ST_T2_MUL, ST_T2_GET,
      ST_TS_MUL, ST_TS_DIV, ST_TS_WAIT,
      ST_TC_MUL, ST_TC_DIV, ST_TC_WAIT,
      ST_TAN_DIV, ST_TAN_WAIT,
      ST_TR_DIV, ST_TR_WAIT,
      ST_DEN_MUL1, ST_DEN_MUL2, ST_DEN_ADD,
      ST_D_DIV, ST_D_WAIT,
      ST_IN_MUL, ST_IN_GET,
      ST_HP_MUL1, ST_HP_MUL2, ST_HP_GET,
      ST_V0_MUL, ST_V0_GET,
      ST_V1_MUL, ST_V1_GET
   } state_type;

   typedef struct packed {
      logic              start;
      logic [DIV_NW-1:0] num;
      logic [DIV_DW-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIV_NW-1:0] quot;
   } div_rsp_type;

   function automatic logic signed [MUL_W-1:0] uext(input logic [MUL_W-2:0] v);
      return $signed({1'b0, v});
   endfunction

   function automatic logic signed [ST_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      if (v > S32_MAX) begin
         return S32_MAX[ST_W-1:0];
      end else if (v < S32_MIN) begin
         return S32_MIN[ST_W-1:0];
      end
      return v[ST_W-1:0];
   endfunction

   // Q4.28 to Q1.23, round half up, saturate
   function automatic logic [X_W-1:0] out24(input logic signed [ST_W-1:0] v);
      logic signed [ST_W:0] r;
      r = (33'(v) + 33'sd16) >>> 5;
      if (r > 33'sd8388607) begin
         return 24'h7F_FFFF;
      end else if (r < -33'sd8388608) begin
         return 24'h80_0000;
      end
      return r[X_W-1:0];
   endfunction

endpackage

// ----- src/tpt_state_variable_filter_core.sv -----
// ----------------------------------------------------------------------------
// tpt_state_variable_filter_core
// Two-pole zero-delay-feedback state variable filter, fixed point, run by a
// sequencer over one shared multiplier and one shared divider.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  req     | in        | req_valid / req_stall | sample, cutoff, Q, end mark
//  rsp     | out       | rsp_valid / rsp_stall | lowpass, bandpass, highpass,
//          |           |                       | block done
//  csr     | in        | csr_valid / csr_ready | sample rate (write only)
//
//  Each item runs four divisions on the 56-step divider (theta, tan, 2R, d)
//  and sixteen Taylor terms on the multiplier; each term is a product with
//  theta squared, then a division by its constant through a reciprocal.
//  req_stall is high from acceptance until the result is loaded.
//  The result register holds while rsp_stall is high; the next item is
//  accepted meanwhile and waits at its final step if the register is full.
//  Synchronous reset: rate 48000, both integrators zero, no result pending.
//  csr writes are taken only while idle and clear both integrators.
// ----------------------------------------------------------------------------
module tpt_state_variable_filter_core
   import svf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic signed [X_W-1:0]  req_audio_sample,
   input  logic [FC_W-1:0]        req_cutoff_hz,
   input  logic [Q_W-1:0]         req_resonance_q,
   input  logic                   req_end_of_block,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [X_W-1:0]  rsp_lowpass_out,
   output logic signed [X_W-1:0]  rsp_bandpass_out,
   output logic signed [X_W-1:0]  rsp_highpass_out,
   output logic                   rsp_block_done,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [FS_W-1:0]        csr_sample_rate
);

   state_type state_ff, state_in;

   // configuration and filter state
   logic [FS_W-1:0]        fs_ff, fs_in;
   logic signed [ST_W-1:0] s0_ff, s0_in;
   logic signed [ST_W-1:0] s1_ff, s1_in;

   // latched item
   logic signed [X_W-1:0]  x_ff, x_in;
   logic [FC_W-1:0]        fc_ff, fc_in;
   logic [Q_W-1:0]         q_ff, q_in;
   logic                   eob_ff, eob_in;

   // coefficient work
   logic [TH_W-1:0]        t_ff, t_in;
   logic [T2_W-1:0]        t2_ff, t2_in;
   logic [TS_W-1:0]        ts_ff, ts_in;
   logic [TS_W-1:0]        tc_ff, tc_in;
   logic signed [SC_W-1:0] s_ff, s_in;
   logic signed [SC_W-1:0] c_ff, c_in;
   logic [2:0]             k_ff, k_in;
   logic [G_W-1:0]         g_ff, g_in;
   logic [TR_W-1:0]        tr_ff, tr_in;
   logic [DEN_W-1:0]       den_ff, den_in;
   logic [D_W-1:0]         d_ff, d_in;
   logic [G0_W-1:0]        g0_ff, g0_in;

   // sample work
   logic signed [IN_W-1:0]   inner_ff, inner_in;
   logic signed [PROD_W-1:0] acc_ff, acc_in;
   logic signed [ST_W-1:0]   hp_ff, hp_in;
   logic signed [ST_W-1:0]   bp_ff, bp_in;

   // result register
   logic                   rv_ff, rv_in;
   logic [X_W-1:0]         lp_o_ff, lp_o_in;
   logic [X_W-1:0]         bp_o_ff, bp_o_in;
   logic [X_W-1:0]         hp_o_ff, hp_o_in;
   logic                   eob_o_ff, eob_o_in;

   // shared units
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic signed [PROD_W-1:0] p_r24;
   div_req_type              div_req;
   div_rsp_type              div_rsp;

   logic req_take, csr_take, out_free;

   logic [SC_W-2:0]          s_cl, c_cl;
   logic signed [PROD_W-1:0] hp_sum, bp_w, lp_w;

   // Taylor term quotient from the reciprocal product
   logic [SH_W-1:0]          rcp_sh;
   logic [PROD_W-1:0]        rcp_q;

   svf_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   svf_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_take = (state_ff == ST_IDLE) && req_valid;
   assign csr_take = (state_ff == ST_IDLE) && csr_valid;
   assign out_free = ~rv_ff | ~rsp_stall;

   // product rounded from Q.24 scaling, half up
   assign p_r24 = (mul_p + HALF24) >>> 24;

   // sin and cos clamp before the tan division
   assign s_cl = s_ff[SC_W-1] ? '0 : s_ff[SC_W-2:0];
   assign c_cl = (c_ff[SC_W-1] || (c_ff == '0)) ? (SC_W-1)'(1) : c_ff[SC_W-2:0];

   assign hp_sum = acc_ff + mul_p;
   assign bp_w   = p_r24 + PROD_W'(s0_ff);
   assign lp_w   = p_r24 + PROD_W'(s1_ff);

   assign rcp_sh = (state_ff == ST_TC_WAIT) ? COS_SH[k_ff] : SIN_SH[k_ff];
   assign rcp_q  = $unsigned(mul_p) >> (7'd32 + 7'(rcp_sh));

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_take) state_in = ST_TH_MUL;
         ST_TH_MUL:   state_in = ST_TH_DIV;
         ST_TH_DIV:   state_in = ST_TH_WAIT;
         ST_TH_WAIT:  if (div_rsp.done) state_in = ST_T2_MUL;
         ST_T2_MUL:   state_in = ST_T2_GET;
         ST_T2_GET:   state_in = ST_TS_MUL;
         ST_TS_MUL:   state_in = ST_TS_DIV;
         ST_TS_DIV:   state_in = ST_TS_WAIT;
         ST_TS_WAIT:  state_in = ST_TC_MUL;
         ST_TC_MUL:   state_in = ST_TC_DIV;
         ST_TC_DIV:   state_in = ST_TC_WAIT;
         ST_TC_WAIT:  state_in = (k_ff == 3'd7) ? ST_TAN_DIV : ST_TS_MUL;
         ST_TAN_DIV:  state_in = ST_TAN_WAIT;
         ST_TAN_WAIT: if (div_rsp.done) state_in = ST_TR_DIV;
         ST_TR_DIV:   state_in = ST_TR_WAIT;
         ST_TR_WAIT:  if (div_rsp.done) state_in = ST_DEN_MUL1;
         ST_DEN_MUL1: state_in = ST_DEN_MUL2;
         ST_DEN_MUL2: state_in = ST_DEN_ADD;
         ST_DEN_ADD:  state_in = ST_D_DIV;
         ST_D_DIV:    state_in = ST_D_WAIT;
         ST_D_WAIT:   if (div_rsp.done) state_in = ST_IN_MUL;
         ST_IN_MUL:   state_in = ST_IN_GET;
         ST_IN_GET:   state_in = ST_HP_MUL1;
         ST_HP_MUL1:  state_in = ST_HP_MUL2;
         ST_HP_MUL2:  state_in = ST_HP_GET;
         ST_HP_GET:   state_in = ST_V0_MUL;
         ST_V0_MUL:   state_in = ST_V0_GET;
         ST_V0_GET:   state_in = ST_V1_MUL;
         ST_V1_MUL:   state_in = ST_V1_GET;
         ST_V1_GET:   if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- unit control
   always_comb begin
      mul_a         = '0;
      mul_b         = '0;
      div_req.start = 1'b0;
      div_req.num   = '0;
      div_req.den   = '0;
      unique case (state_ff)
         ST_TH_MUL: begin
            mul_a = uext(33'(fc_ff));
            mul_b = uext(33'(PI_Q30));
         end
         ST_TH_DIV: begin
            div_req.start = 1'b1;
            div_req.num   = mul_p[DIV_NW-1:0] + DIV_NW'(fs_ff >> 1);
            div_req.den   = DIV_DW'(fs_ff);
         end
         ST_T2_MUL: begin
            mul_a = uext(33'(t_ff));
            mul_b = uext(33'(t_ff));
         end
         ST_TS_MUL: begin
            mul_a = uext(33'(ts_ff));
            mul_b = uext(33'(t2_ff));
         end
         ST_TS_DIV: begin
            // term numerator stays below 2^32 with theta capped
            mul_a = uext(33'(mul_p[61:30]));
            mul_b = uext(SIN_RCP[k_ff]);
         end
         ST_TC_MUL: begin
            mul_a = uext(33'(tc_ff));
            mul_b = uext(33'(t2_ff));
         end
         ST_TC_DIV: begin
            mul_a = uext(33'(mul_p[61:30]));
            mul_b = uext(COS_RCP[k_ff]);
         end
         ST_TAN_DIV: begin
            div_req.start = 1'b1;
            div_req.num   = (DIV_NW'(s_cl) << 24) + DIV_NW'(c_cl >> 1);
            div_req.den   = DIV_DW'(c_cl);
         end
         ST_TR_DIV: begin
            div_req.start = 1'b1;
            div_req.num   = (DIV_NW'(1) << 36) + DIV_NW'(q_ff >> 1);
            div_req.den   = DIV_DW'(q_ff);
         end
         ST_DEN_MUL1: begin
            mul_a = uext(33'(tr_ff));
            mul_b = uext(33'(g_ff));
         end
         ST_DEN_MUL2: begin
            mul_a = uext(33'(g_ff));
            mul_b = uext(33'(g_ff));
         end
         ST_D_DIV: begin
            div_req.start = 1'b1;
            div_req.num   = (DIV_NW'(1) << 50) + DIV_NW'(den_ff >> 1);
            div_req.den   = DIV_DW'(den_ff);
         end
         ST_IN_MUL: begin
            mul_a = uext(33'(g0_ff));
            mul_b = MUL_W'(s0_ff);
         end
         ST_HP_MUL1: begin
            // upper part of the 40-bit inner term, signed
            mul_a = MUL_W'(inner_ff >>> 20);
            mul_b = uext(33'(d_ff));
         end
         ST_HP_MUL2: begin
            mul_a = uext(33'(inner_ff[19:0]));
            mul_b = uext(33'(d_ff));
         end
         ST_V0_MUL: begin
            mul_a = uext(33'(g_ff));
            mul_b = MUL_W'(hp_ff);
         end
         ST_V1_MUL, ST_V1_GET: begin
            // held in the last step so the product survives an output stall
            mul_a = uext(33'(g_ff));
            mul_b = MUL_W'(bp_ff);
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      fs_in    = fs_ff;
      s0_in    = s0_ff;
      s1_in    = s1_ff;
      x_in     = x_ff;
      fc_in    = fc_ff;
      q_in     = q_ff;
      eob_in   = eob_ff;
      t_in     = t_ff;
      t2_in    = t2_ff;
      ts_in    = ts_ff;
      tc_in    = tc_ff;
      s_in     = s_ff;
      c_in     = c_ff;
      k_in     = k_ff;
      g_in     = g_ff;
      tr_in    = tr_ff;
      den_in   = den_ff;
      d_in     = d_ff;
      g0_in    = g0_ff;
      inner_in = inner_ff;
      acc_in   = acc_ff;
      hp_in    = hp_ff;
      bp_in    = bp_ff;
      rv_in    = rv_ff & rsp_stall;
      lp_o_in  = lp_o_ff;
      bp_o_in  = bp_o_ff;
      hp_o_in  = hp_o_ff;
      eob_o_in = eob_o_ff;

      if (csr_take) begin
         if (csr_sample_rate < FS_MIN) begin
            fs_in = FS_MIN;
         end else if (csr_sample_rate > FS_MAX) begin
            fs_in = FS_MAX;
         end else begin
            fs_in = csr_sample_rate;
         end
         s0_in = '0;
         s1_in = '0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               x_in   = req_audio_sample;
               eob_in = req_end_of_block;
               if (req_cutoff_hz < FC_MIN) begin
                  fc_in = FC_MIN;
               end else if (req_cutoff_hz > FC_MAX) begin
                  fc_in = FC_MAX;
               end else begin
                  fc_in = req_cutoff_hz;
               end
               if (req_resonance_q < Q_MIN) begin
                  q_in = Q_MIN;
               end else if (req_resonance_q > Q_MAX) begin
                  q_in = Q_MAX;
               end else begin
                  q_in = req_resonance_q;
               end
            end
         end
         ST_TH_WAIT: begin
            if (div_rsp.done) begin
               t_in = (div_rsp.quot > DIV_NW'(THETA_CAP)) ? THETA_CAP
                                                          : div_rsp.quot[TH_W-1:0];
            end
         end
         ST_T2_GET: begin
            t2_in = mul_p[61:30];
            ts_in = TS_W'(t_ff);
            tc_in = ONE_Q30;
            s_in  = $signed(SC_W'(t_ff));
            c_in  = $signed(SC_W'(ONE_Q30));
            k_in  = '0;
         end
         ST_TS_WAIT: begin
            ts_in = rcp_q[TS_W-1:0];
            // odd terms of the series subtract
            if (k_ff[0] == 1'b0) begin
               s_in = s_ff - $signed(SC_W'(rcp_q[TS_W-1:0]));
            end else begin
               s_in = s_ff + $signed(SC_W'(rcp_q[TS_W-1:0]));
            end
         end
         ST_TC_WAIT: begin
            tc_in = rcp_q[TS_W-1:0];
            if (k_ff[0] == 1'b0) begin
               c_in = c_ff - $signed(SC_W'(rcp_q[TS_W-1:0]));
            end else begin
               c_in = c_ff + $signed(SC_W'(rcp_q[TS_W-1:0]));
            end
            k_in = k_ff + 3'd1;
         end
         ST_TAN_WAIT: begin
            if (div_rsp.done) begin
               g_in = div_rsp.quot[G_W-1:0];
            end
         end
         ST_TR_WAIT: begin
            if (div_rsp.done) begin
               tr_in = div_rsp.quot[TR_W-1:0];
            end
         end
         ST_DEN_MUL2: begin
            den_in = ONE_Q24 + DEN_W'(p_r24);
         end
         ST_DEN_ADD: begin
            den_in = den_ff + DEN_W'(p_r24);
            g0_in  = G0_W'(tr_ff) + G0_W'(g_ff);
         end
         ST_D_WAIT: begin
            if (div_rsp.done) begin
               d_in = div_rsp.quot[D_W-1:0];
            end
         end
         ST_IN_GET: begin
            inner_in = (IN_W'(x_ff) <<< 5) - IN_W'(s1_ff) - IN_W'(p_r24);
         end
         ST_HP_MUL2: begin
            acc_in = mul_p <<< 20;
         end
         ST_HP_GET: begin
            hp_in = sat32((hp_sum + HALF26) >>> 26);
         end
         ST_V0_GET: begin
            s0_in = sat32(bp_w + p_r24);
            bp_in = sat32(bp_w);
         end
         ST_V1_GET: begin
            if (out_free) begin
               s1_in    = sat32(lp_w + p_r24);
               rv_in    = 1'b1;
               lp_o_in  = out24(sat32(lp_w));
               bp_o_in  = out24(bp_ff);
               hp_o_in  = out24(hp_ff);
               eob_o_in = eob_ff;
            end
         end
         default: begin
            rv_in = rv_ff & rsp_stall;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
         fs_ff    <= FS_RESET;
         s0_ff    <= '0;
         s1_ff    <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         fs_ff    <= fs_in;
         s0_ff    <= s0_in;
         s1_ff    <= s1_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      fc_ff    <= fc_in;
      q_ff     <= q_in;
      eob_ff   <= eob_in;
      t_ff     <= t_in;
      t2_ff    <= t2_in;
      ts_ff    <= ts_in;
      tc_ff    <= tc_in;
      s_ff     <= s_in;
      c_ff     <= c_in;
      k_ff     <= k_in;
      g_ff     <= g_in;
      tr_ff    <= tr_in;
      den_ff   <= den_in;
      d_ff     <= d_in;
      g0_ff    <= g0_in;
      inner_ff <= inner_in;
      acc_ff   <= acc_in;
      hp_ff    <= hp_in;
      bp_ff    <= bp_in;
      lp_o_ff  <= lp_o_in;
      bp_o_ff  <= bp_o_in;
      hp_o_ff  <= hp_o_in;
      eob_o_ff <= eob_o_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign csr_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rv_ff;
   assign rsp_lowpass_out  = $signed(lp_o_ff);
   assign rsp_bandpass_out = $signed(bp_o_ff);
   assign rsp_highpass_out = $signed(hp_o_ff);
   assign rsp_block_done   = eob_o_ff;

endmodule

// ----- src/svf_mul.sv -----
// ----------------------------------------------------------------------------
// svf_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module svf_mul
   import svf_pkg::*;
(
   input  logic                     clock,
   input  logic signed [MUL_W-1:0]  mul_a,
   input  logic signed [MUL_W-1:0]  mul_b,
   output logic signed [PROD_W-1:0] mul_p
);

   logic signed [PROD_W-1:0] p_ff;

   always_ff @(posedge clock) begin
      p_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   assign mul_p = p_ff;

endmodule

// ----- src/svf_div.sv -----
// ----------------------------------------------------------------------------
// svf_div
// Shared restoring divider, unsigned, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module svf_div
   import svf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam logic [DIV_CW-1:0] LAST_STEP = DIV_CW'(DIV_NW - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic [DIV_DW-1:0] rem_ff, rem_in;
   logic [DIV_NW-1:0] quo_ff, quo_in;
   logic [DIV_DW-1:0] den_ff, den_in;

   logic [DIV_DW:0]   rem_sh;
   logic [DIV_DW+1:0] diff;
   logic              ge;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[DIV_NW-1]};
      diff   = {1'b0, rem_sh} - {2'b00, den_ff};
      ge     = ~diff[DIV_DW+1];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = LAST_STEP;
         rem_in  = '0;
         quo_in  = div_req.num;
         den_in  = div_req.den;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
         quo_in = {quo_ff[DIV_NW-2:0], ge};
         cnt_in = cnt_ff - DIV_CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quo_ff;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the state variable filter core: a queue-fed driver
// offers samples, a bit-exact fixed-point filter predictor computes each
// lowpass/bandpass/highpass item, and a monitor checks them in order across
// several sample rates and idling patterns.
// ----------------------------------------------------------------------------
module tb_top
   import svf_pkg::*;
;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 1300;
   localparam int HOLD_CYCLES    = 4000;

   typedef struct {
      logic signed [X_W-1:0] sample;
      logic [FC_W-1:0]       cutoff;
      logic [Q_W-1:0]        q;
      logic                  eob;
   } sample_item_type;

   typedef struct {
      logic [X_W-1:0] lp;
      logic [X_W-1:0] bp;
      logic [X_W-1:0] hp;
      logic           done;
   } filter_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic signed [X_W-1:0] req_audio_sample = '0;
   logic [FC_W-1:0]       req_cutoff_hz = '0;
   logic [Q_W-1:0]        req_resonance_q = '0;
   logic                  req_end_of_block = 1'b0;

   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic signed [X_W-1:0] rsp_lowpass_out;
   logic signed [X_W-1:0] rsp_bandpass_out;
   logic signed [X_W-1:0] rsp_highpass_out;
   logic                  rsp_block_done;

   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [FS_W-1:0]       csr_sample_rate = '0;

   // Pending samples and expected filter outputs
   sample_item_type sample_q[$];
   filter_out_type  filter_out_q[$];

   // Predictor state: rate and the two Q4.28 integrators
   longint unsigned   rate_hz = 48000;
   logic signed [31:0] bp_integ = '0;
   logic signed [31:0] lp_integ = '0;

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  hold_request  = 0;
   int  hold_served   = 0;
   int  hold_left     = 0;
   int  errors        = 0;
   int  samples_in    = 0;
   int  items_out     = 0;
   int  rate_writes   = 0;
   int  quiet_cycles  = 0;

   tpt_state_variable_filter_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_audio_sample (req_audio_sample),
      .req_cutoff_hz    (req_cutoff_hz),
      .req_resonance_q  (req_resonance_q),
      .req_end_of_block (req_end_of_block),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_lowpass_out  (rsp_lowpass_out),
      .rsp_bandpass_out (rsp_bandpass_out),
      .rsp_highpass_out (rsp_highpass_out),
      .rsp_block_done   (rsp_block_done),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_sample_rate  (csr_sample_rate)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Fixed-point helpers
   // ---------------------------------------------------------------------
   // Round half toward plus infinity; >>> floors, matching the spec
   function automatic longint round_shift(longint v, int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint clip32(longint v);
      return clip(v, -(longint'(1) <<< 31), (longint'(1) <<< 31) - 1);
   endfunction

   function automatic logic [X_W-1:0] to_q23(longint q28);
      longint v;
      v = clip(round_shift(q28, 5), -(longint'(1) <<< 23), (longint'(1) <<< 23) - 1);
      return v[X_W-1:0];
   endfunction

   // tan(theta), theta Q2.30 -> Q8.24, via truncated Taylor sin/cos
   function automatic longint unsigned prewarp_tan(longint unsigned t);
      longint unsigned t2, ts, tc, div_s, div_c;
      longint s, c;
      int k;
      t2 = (t * t) >> 30;
      ts = t;
      tc = longint'(1) << 30;
      s  = longint'(t);
      c  = longint'(1) << 30;
      for (k = 1; k <= 8; k++) begin
         div_s = longint'((2 * k) * (2 * k + 1));
         div_c = longint'((2 * k - 1) * (2 * k));
         ts = ((ts * t2) >> 30) / div_s;
         tc = ((tc * t2) >> 30) / div_c;
         if (k % 2 == 1) begin
            s = s - longint'(ts);
            c = c - longint'(tc);
         end else begin
            s = s + longint'(ts);
            c = c + longint'(tc);
         end
      end
      if (s < 0) s = 0;
      if (c < 1) c = 1;
      return ((longint'(s) << 24) + (longint'(c) >> 1)) / longint'(c);
   endfunction

   // One filter step: coefficients from this item's cutoff and Q, then the
   // zero-delay-feedback update of both integrators.
   task automatic filter_step(input sample_item_type it, output filter_out_type res);
      longint unsigned fc, q, theta, g, two_r, den, d, g0;
      longint x, s0, s1, inner, hp, v0, bp_w, bp, v1, lp_w, lp;
      x  = longint'(it.sample);
      fc = it.cutoff;
      q  = it.q;
      if (fc < 20) fc = 20;
      if (fc > 20000) fc = 20000;
      if (q < 410) q = 410;
      if (q > 40960) q = 40960;
      s0 = longint'(bp_integ);
      s1 = longint'(lp_integ);

      theta = (fc * 64'd3373259426 + rate_hz / 2) / rate_hz;
      if (theta > 64'd1652897119) theta = 64'd1652897119;   // cap at 0.49*pi
      g     = prewarp_tan(theta);
      two_r = ((64'd1 << 36) + q / 2) / q;
      den   = (64'd1 << 24) + ((two_r * g + (64'd1 << 23)) >> 24)
              + ((g * g + (64'd1 << 23)) >> 24);
      d     = ((64'd1 << 50) + den / 2) / den;
      g0    = two_r + g;

      inner = x * 32 - s1 - round_shift(longint'(g0) * s0, 24);
      hp    = clip32(round_shift(inner * longint'(d), 26));
      v0    = round_shift(longint'(g) * hp, 24);
      bp_w  = v0 + s0;
      bp_integ = 32'(clip32(bp_w + v0));
      bp    = clip32(bp_w);
      v1    = round_shift(longint'(g) * bp, 24);
      lp_w  = v1 + s1;
      lp_integ = 32'(clip32(lp_w + v1));
      lp    = clip32(lp_w);

      res.lp   = to_q23(lp);
      res.bp   = to_q23(bp);
      res.hp   = to_q23(hp);
      res.done = it.eob;
   endtask

   // ---------------------------------------------------------------------
   // Driver: pops pending samples; predicts on each accepted item
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      sample_item_type it, acc;
      filter_out_type  res;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            acc.sample = req_audio_sample;
            acc.cutoff = req_cutoff_hz;
            acc.q      = req_resonance_q;
            acc.eob    = req_end_of_block;
            filter_step(acc, res);
            filter_out_q.push_back(res);
            samples_in++;
         end
         // payload only moves when the slot is free (not stalled)
         if (!req_valid || !req_stall) begin
            if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               it = sample_q.pop_front();
               req_valid        <= 1'b1;
               req_audio_sample <= it.sample;
               req_cutoff_hz    <= it.cutoff;
               req_resonance_q  <= it.q;
               req_end_of_block <= it.eob;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: checks each accepted item against the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      filter_out_type ex;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            items_out++;
            if (filter_out_q.size() == 0) begin
               $error("unexpected item on rsp");
               errors++;
            end else begin
               ex = filter_out_q.pop_front();
               if (rsp_lowpass_out !== ex.lp) begin
                  $error("lowpass_out exp %h got %h", ex.lp, rsp_lowpass_out);
                  errors++;
               end
               if (rsp_bandpass_out !== ex.bp) begin
                  $error("bandpass_out exp %h got %h", ex.bp, rsp_bandpass_out);
                  errors++;
               end
               if (rsp_highpass_out !== ex.hp) begin
                  $error("highpass_out exp %h got %h", ex.hp, rsp_highpass_out);
                  errors++;
               end
               if (rsp_block_done !== ex.done) begin
                  $error("block_done exp %b got %b", ex.done, rsp_block_done);
                  errors++;
               end
            end
         end
      end
      // long hold-off requested by the sequence, counted here
      if (hold_request != hold_served) begin
         hold_served = hold_request;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Watchdog: cycles with no handshake on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_top NOT OK");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   task automatic add_sample(logic signed [X_W-1:0] s, logic [FC_W-1:0] fc,
                             logic [Q_W-1:0] q, logic eob);
      sample_item_type it;
      it.sample = s;
      it.cutoff = fc;
      it.q      = q;
      it.eob    = eob;
      sample_q.push_back(it);
   endtask

   // sender pause: nothing pending, nothing in flight
   task automatic wait_drained();
      while (sample_q.size() > 0 || req_valid || filter_out_q.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_rate(logic [FS_W-1:0] v);
      longint unsigned r;
      csr_valid       <= 1'b1;
      csr_sample_rate <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      r = v;
      if (r < 8000) r = 8000;
      if (r > 192000) r = 192000;
      rate_hz  = r;
      bp_integ = '0;           // a rate write clears both integrators
      lp_integ = '0;
      rate_writes++;
   endtask

   task automatic add_random(int n);
      int i;
      logic [FC_W-1:0] fc;
      logic [Q_W-1:0]  q;
      for (i = 0; i < n; i++) begin
         if ($urandom_range(99) < 70) begin
            // musical range, occasional block marker
            fc = FC_W'($urandom_range(20000, 20));
            q  = Q_W'($urandom_range(40960, 410));
         end else begin
            fc = FC_W'($urandom);
            q  = Q_W'($urandom);
         end
         add_sample(X_W'($urandom), fc, q, ($urandom_range(15) == 0));
      end
   endtask

   logic [FS_W-1:0] rate_plan [0:5] = '{18'd8000, 18'd192000, 18'd0,
                                        18'h3FFFF, 18'd44100, 18'd96000};

   initial begin
      int ph;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, clamps, cap near half rate, saturation
      send_idle_pct = 22;
      recv_idle_pct = 51;
      add_sample(24'sd0, 16'd1000, 16'd4096, 1'b0);
      add_sample(24'sh7FFFFF, 16'd0, 16'd0, 1'b0);
      add_sample(-24'sh800000, 16'd20, 16'd410, 1'b1);
      add_sample(24'sh7FFFFF, 16'd20000, 16'd40960, 1'b0);
      add_sample(-24'sh800000, 16'hFFFF, 16'hFFFF, 1'b0);
      add_sample(24'sh400000, 16'd24000, 16'd2896, 1'b1);
      add_sample(-24'sh400000, 16'd23999, 16'd409, 1'b0);
      add_sample(24'sd1, 16'd19, 16'd40961, 1'b0);
      add_sample(-24'sd1, 16'd20001, 16'd1, 1'b1);
      // loud input at max Q drives the integrators into saturation
      repeat (8) add_sample(24'sh7FFFFF, 16'd200, 16'hFFFF, 1'b0);
      repeat (4) add_sample(-24'sh800000, 16'd200, 16'hFFFF, 1'b0);
      add_sample(24'sh000000, 16'd200, 16'hFFFF, 1'b1);
      wait_drained();

      for (ph = 0; ph < 6; ph++) begin
         if (ph < 2) begin
            send_idle_pct = 22;
            recv_idle_pct = 51;
         end else if (ph < 4) begin
            send_idle_pct = 51;
            recv_idle_pct = 22;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_rate(rate_plan[ph]);
         add_random(205);
         if (ph == 4) begin
            // receiver holds off while the sender keeps offering
            wait (samples_in > 0 && sample_q.size() < 200);
            hold_request++;
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d samples, %0d items checked, %0d rate writes",
               samples_in, items_out, rate_writes);
      $display("rates 8000..192000 incl. saturated writes, clamped Q/cutoff, errors %0d",
               errors);
      if (errors == 0 && filter_out_q.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
